/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the list datapath RTL.
// Define NO_ASSERTIONS to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// check masked while reset is active
`define ALIST_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// check that also holds through reset
`define ALIST_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ALIST_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define ALIST_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

/* design/alist_pkg.sv */
// ---------------------------------------------------------------------------
// alist_pkg
// Constants, command codes and controller/datapath interface types for the
// sequential array list.
// ---------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

	localparam int DEPTH  = 64;
	localparam int ITEM_W = 32;
	localparam int CMD_W  = 3;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RM_TAIL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RM_HEAD  = 3'd4;

	// memory read address source
	typedef enum logic [1:0] {
		RD_HEAD   = 2'd0,
		RD_TAIL   = 2'd1,
		RD_IDX    = 2'd2,
		RD_IDX_M1 = 2'd3
	} alist_rd_t;

	// memory write address source
	typedef enum logic {
		WA_IDX    = 1'b0,
		WA_IDX_M1 = 1'b1
	} alist_wa_t;

	// index counter operation
	typedef enum logic [2:0] {
		IDX_HOLD = 3'd0,
		IDX_CNT  = 3'd1,
		IDX_ONE  = 3'd2,
		IDX_DEC  = 3'd3,
		IDX_INC  = 3'd4
	} alist_idx_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		alist_rd_t  rd_sel;
		logic       wr_en;
		alist_wa_t  wr_sel;
		logic       wr_item;
		alist_idx_t idx_op;
		logic       cap_removed;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       set_ok;
		logic       res_load;
	} alist_ctl_t;

	typedef struct packed {
		logic legal;
		logic is_insert;
		logic is_rm_tail;
		logic is_rm_head;
		logic at_target;
		logic at_count;
		logic out_free;
	} alist_sts_t;

endpackage

`default_nettype wire

/* design/alist_dpath.sv */
// ---------------------------------------------------------------------------
// alist_dpath
// List storage, entry counter, shift index and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module alist_dpath import alist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CMD_W-1:0]  command,
	input  logic [ITEM_W-1:0] item_value,
	input  logic [CNT_W-1:0]  position,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output logic              ok,
	output logic [ITEM_W-1:0] removed_value,
	output logic [CNT_W-1:0]  count,
	output logic              is_empty,
	output logic              is_full,
	input  alist_ctl_t        ctl,
	output alist_sts_t        sts
);

	logic [ITEM_W-1:0] mem_q [DEPTH];
	logic [ITEM_W-1:0] rdata_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [ITEM_W-1:0] item_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ITEM_W-1:0] removed_q;
	logic              ok_q;

	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [ITEM_W-1:0] rsp_removed_q;
	logic [CNT_W-1:0]  rsp_count_q;
	logic              rsp_empty_q;
	logic              rsp_full_q;

	logic [CNT_W-1:0]  idx_m1;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  target;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [ITEM_W-1:0] wr_data;
	logic              legal;

	assign idx_m1 = idx_q - CNT_W'(1);
	assign cnt_m1 = cnt_q - CNT_W'(1);

	always_comb begin
		case (ctl.rd_sel)
			RD_HEAD:   rd_addr = '0;
			RD_TAIL:   rd_addr = cnt_m1[ADDR_W-1:0];
			RD_IDX:    rd_addr = idx_q[ADDR_W-1:0];
			RD_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
			default:   rd_addr = '0;
		endcase
	end

	assign wr_addr = (ctl.wr_sel == WA_IDX_M1) ? idx_m1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
	assign wr_data = ctl.wr_item ? item_q : rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// insert slot: tail is the current count, head is slot zero
	always_comb begin
		case (cmd_q)
			CMD_INS_TAIL: target = cnt_q;
			CMD_INS_HEAD: target = '0;
			default:      target = pos_q;
		endcase
	end

	always_comb begin
		case (cmd_q)
			CMD_INS_TAIL, CMD_INS_HEAD: legal = (cnt_q != FULL_CNT);
			CMD_INS_POS:                legal = (cnt_q != FULL_CNT) && (pos_q <= cnt_q);
			CMD_RM_TAIL, CMD_RM_HEAD:   legal = (cnt_q != '0);
			default:                    legal = 1'b0;
		endcase
	end

	always_comb begin
		sts.legal      = legal;
		sts.is_insert  = cmd_q inside {CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_POS};
		sts.is_rm_tail = (cmd_q == CMD_RM_TAIL);
		sts.is_rm_head = (cmd_q == CMD_RM_HEAD);
		sts.at_target  = (idx_q == target);
		sts.at_count   = (idx_q == cnt_q);
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			item_q <= item_value;
			pos_q  <= position;
		end
		if (ctl.load) begin
			removed_q <= '0;
		end else if (ctl.cap_removed) begin
			removed_q <= rdata_q;
		end
		if (ctl.res_load) begin
			rsp_ok_q      <= ok_q;
			rsp_removed_q <= removed_q;
			rsp_count_q   <= cnt_q;
			rsp_empty_q   <= (cnt_q == '0);
			rsp_full_q    <= (cnt_q == FULL_CNT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctl.cnt_dec) begin
				cnt_q <= cnt_m1;
			end

			case (ctl.idx_op)
				IDX_HOLD: idx_q <= idx_q;
				IDX_CNT:  idx_q <= cnt_q;
				IDX_ONE:  idx_q <= CNT_W'(1);
				IDX_DEC:  idx_q <= idx_m1;
				IDX_INC:  idx_q <= idx_q + CNT_W'(1);
				default:  idx_q <= idx_q;
			endcase

			if (ctl.load) begin
				ok_q <= 1'b0;
			end else if (ctl.set_ok) begin
				ok_q <= 1'b1;
			end

			// res_load is only issued when the register is free
			if (ctl.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign ok            = rsp_ok_q;
	assign removed_value = rsp_removed_q;
	assign count         = rsp_count_q;
	assign is_empty      = rsp_empty_q;
	assign is_full       = rsp_full_q;

	`ALIST_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= FULL_CNT, "entry count beyond depth")
	`ALIST_ASSERT(a_cnt_step, clk, arst_n, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + 1) || (cnt_q + 1 == $past(cnt_q))), "entry count moved by more than one")
	`ALIST_ASSERT(a_cnt_excl, clk, arst_n, !(ctl.cnt_inc && ctl.cnt_dec), "count increment and decrement together")
	`ALIST_ASSERT(a_wr_range, clk, arst_n, ctl.wr_en |-> (idx_q <= cnt_q), "write beyond list end")

endmodule

`default_nettype wire

/* design/alist_ctrl.sv */
// ---------------------------------------------------------------------------
// alist_ctrl
// Sequencer for the list: checks the command, walks the entry moves one
// at a time and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module alist_ctrl import alist_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  alist_sts_t sts,
	output alist_ctl_t ctl
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_CHECK    = 10'b00_0000_0010,
		ST_INS_TEST = 10'b00_0000_0100,
		ST_INS_MOVE = 10'b00_0000_1000,
		ST_INS_PUT  = 10'b00_0001_0000,
		ST_RT_CAP   = 10'b00_0010_0000,
		ST_RH_CAP   = 10'b00_0100_0000,
		ST_RH_TEST  = 10'b00_1000_0000,
		ST_RH_MOVE  = 10'b01_0000_0000,
		ST_RESULT   = 10'b10_0000_0000
	} alist_state_t;

	alist_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.legal) begin
					state_d = ST_RESULT;
				end else if (sts.is_insert) begin
					ctl.idx_op = IDX_CNT;
					state_d    = ST_INS_TEST;
				end else if (sts.is_rm_tail) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_TAIL;
					state_d    = ST_RT_CAP;
				end else if (sts.is_rm_head) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_HEAD;
					state_d    = ST_RH_CAP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			// shift up from the tail down to the insert slot
			ST_INS_TEST: begin
				if (sts.at_target) begin
					state_d = ST_INS_PUT;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX_M1;
					state_d    = ST_INS_MOVE;
				end
			end
			ST_INS_MOVE: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WA_IDX;
				ctl.idx_op = IDX_DEC;
				state_d    = ST_INS_TEST;
			end
			ST_INS_PUT: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_sel  = WA_IDX;
				ctl.wr_item = 1'b1;
				ctl.cnt_inc = 1'b1;
				ctl.set_ok  = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_RT_CAP: begin
				ctl.cap_removed = 1'b1;
				ctl.cnt_dec     = 1'b1;
				ctl.set_ok      = 1'b1;
				state_d         = ST_RESULT;
			end
			ST_RH_CAP: begin
				ctl.cap_removed = 1'b1;
				ctl.idx_op      = IDX_ONE;
				state_d         = ST_RH_TEST;
			end
			// shift down from slot one up to the tail
			ST_RH_TEST: begin
				if (sts.at_count) begin
					ctl.cnt_dec = 1'b1;
					ctl.set_ok  = 1'b1;
					state_d     = ST_RESULT;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX;
					state_d    = ST_RH_MOVE;
				end
			end
			ST_RH_MOVE: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WA_IDX_M1;
				ctl.idx_op = IDX_INC;
				state_d    = ST_RH_TEST;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/array_list_insert_remove.sv */
// ---------------------------------------------------------------------------
// array_list_insert_remove
// Bounded list of DEPTH words with insert and remove commands.
// ---------------------------------------------------------------------------
// Request channel (req_valid/req_stall): command, item_value, position.
// Commands: insert at tail, insert at head, insert at position, remove from
// tail, remove from head. Each request gives exactly one response
// (rsp_valid/rsp_stall) carrying ok, removed_value and the count, empty and
// full state after the command. Refused commands leave the list unchanged.
// Entries live in a single-port style memory (one read, one write a cycle,
// registered read), so each moved entry takes a read state and a write state.
// An insert checks the command, moves each entry from the tail down to its
// slot up by one and writes the item; remove from head captures slot zero
// and moves each later entry down by one; remove from tail captures the
// tail entry. A refused command goes straight to the response.
// The response is registered; it appears in the same cycle that the next request
// can be taken. One transaction is in the list at a time; req_stall is high
// while it is worked on.
// A stalled response holds; the list finishes its work and then waits with
// the next result until the response register is free.
// Reset clears the count and both handshakes; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module array_list_insert_remove import alist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [ITEM_W-1:0] item_value,
	input  logic [CNT_W-1:0]  position,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              ok,
	output logic [ITEM_W-1:0] removed_value,
	output logic [CNT_W-1:0]  count,
	output logic              is_empty,
	output logic              is_full
);

	alist_ctl_t ctl;
	alist_sts_t sts;

	alist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	alist_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.item_value    (item_value),
		.position      (position),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.ok            (ok),
		.removed_value (removed_value),
		.count         (count),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.ctl           (ctl),
		.sts           (sts)
	);

endmodule

`default_nettype wire
